### hw/rtl/bfop_pkg.sv
// ----------------------------------------------------------------------------
// bfop_pkg: shared types and constants for the bounded FIFO unit
// Operation, status and mode codes, widths and the pointer step function.
// ----------------------------------------------------------------------------
`default_nettype none

package bfop_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int LIMIT_W    = 5;
	localparam int MODE_W     = 2;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;

	localparam int IN_BITS    = OP_W + DATA_WIDTH;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = STATUS_W + DATA_WIDTH + CNT_W + 1;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLOSE = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED = 3'd0,
		ST_REPLACED = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_REJECTED = 3'd3,
		ST_IGNORED  = 3'd4,
		ST_POPPED   = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_DROP_OLDEST = 2'd0,
		MODE_DROP_NEWEST = 2'd1,
		MODE_REJECT      = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUEUE_LIMIT   = 1'd0,
		REG_OVERFLOW_MODE = 1'd1
	} reg_idx_t;

	// ring pointer step with wrap at DEPTH
	function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
		logic [PTR_W-1:0] r;
		if (i == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/bounded_fifo_overflow_policy_unit.sv
// ----------------------------------------------------------------------------
// bounded_fifo_overflow_policy_unit: bounded FIFO with overflow policy
// Push / pop / close queue of data words; full pushes follow the overflow mode.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake         Contents
//  s_*       in   tvalid / tready   operation, push_data
//  m_*       out  tvalid / tready   status, pop_data, occupancy, closed
//  cfg_*     in   cfg_we only       queue_limit (idx 0), overflow_mode (idx 1)
//
//  One item per cycle unless the output stalls; each result appears in
//  the cycle after its item is taken. The rate is set by the read-modify
//  of the pointer and count registers against the store's one write and
//  one read port. The result register doubles as output stage: s_tready
//  drops only while a result is held and m_tready is low. Reset clears
//  pointers, count, closed flag and registers; the word store is not cleared.
//
`default_nettype none

module bounded_fifo_overflow_policy_unit (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// slave side
	input  wire logic                                    s_tvalid,
	output      logic                                    s_tready,
	// [1:0] operation, [33:2] push_data, rest zero
	input  wire logic [bfop_pkg::IN_TDATA_W-1:0]         s_tdata,
	// master side
	output      logic                                    m_tvalid,
	input  wire logic                                    m_tready,
	// [2:0] status, [34:3] pop_data, [39:35] occupancy, [40] closed, rest zero
	output      logic [bfop_pkg::OUT_TDATA_W-1:0]        m_tdata,
	// configuration write port
	input  wire logic                                    cfg_we,
	input  wire logic [bfop_pkg::CFG_IDX_W-1:0]          cfg_idx,
	input  wire logic [bfop_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

	// word store: one write (tail) and one registered read (head) per cycle
	logic [bfop_pkg::DATA_WIDTH-1:0] store_mem [bfop_pkg::DEPTH];

	// control state
	logic [bfop_pkg::PTR_W-1:0]   head_q, tail_q;
	logic [bfop_pkg::CNT_W-1:0]   count_q;
	logic                         closed_q;
	logic [bfop_pkg::LIMIT_W-1:0] limit_q;
	bfop_pkg::mode_t              mode_q;

	// result stage
	logic                              valid_s1;
	bfop_pkg::status_t                 status_s1;
	logic                              popped_s1;
	logic [bfop_pkg::CNT_W-1:0]        occ_s1;
	logic                              closed_s1;
	logic [bfop_pkg::DATA_WIDTH-1:0]   rdata_s1;

	// decode
	logic                              accept;
	bfop_pkg::op_t                     op;
	logic [bfop_pkg::DATA_WIDTH-1:0]   word;
	logic [bfop_pkg::CNT_W-1:0]        lim_eff;
	logic                              full;
	logic                              do_append, do_remove, do_close;
	bfop_pkg::status_t                 status_d;
	logic [bfop_pkg::CNT_W-1:0]        count_d;

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = bfop_pkg::op_t'(s_tdata[bfop_pkg::OP_W-1:0]);
	assign word     = s_tdata[bfop_pkg::OP_W +: bfop_pkg::DATA_WIDTH];

	// usable capacity: zero acts as one, anything past the store is clamped
	always_comb begin
		if (limit_q == '0) begin
			lim_eff = bfop_pkg::CNT_W'(1);
		end else if ({1'b0, limit_q} > (bfop_pkg::LIMIT_W + 1)'(bfop_pkg::DEPTH)) begin
			lim_eff = bfop_pkg::CNT_W'(bfop_pkg::DEPTH);
		end else begin
			lim_eff = bfop_pkg::CNT_W'(limit_q);
		end
	end

	// a lowered limit below the occupancy still counts as full
	assign full = ({1'b0, count_q} >= {1'b0, lim_eff});

	always_comb begin
		do_append = 1'b0;
		do_remove = 1'b0;
		do_close  = 1'b0;
		status_d  = bfop_pkg::ST_IGNORED;
		unique case (op)
			bfop_pkg::OP_PUSH: begin
				if (closed_q) begin
					status_d = bfop_pkg::ST_IGNORED;
				end else if (full) begin
					unique case (mode_q)
						bfop_pkg::MODE_DROP_OLDEST: begin
							// evict head and append: count unchanged
							do_remove = 1'b1;
							do_append = 1'b1;
							status_d  = bfop_pkg::ST_REPLACED;
						end
						bfop_pkg::MODE_DROP_NEWEST: status_d = bfop_pkg::ST_DROPPED;
						default:                    status_d = bfop_pkg::ST_REJECTED;
					endcase
				end else begin
					do_append = 1'b1;
					status_d  = bfop_pkg::ST_APPENDED;
				end
			end
			bfop_pkg::OP_POP: begin
				if (count_q == '0) begin
					status_d = bfop_pkg::ST_EMPTY;
				end else begin
					do_remove = 1'b1;
					status_d  = bfop_pkg::ST_POPPED;
				end
			end
			bfop_pkg::OP_CLOSE: begin
				do_close = 1'b1;
				status_d = bfop_pkg::ST_IGNORED;
			end
			default: status_d = bfop_pkg::ST_IGNORED;   // unused code: no effect
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (do_append && !do_remove) begin
			count_d = count_q + bfop_pkg::CNT_W'(1);
		end else if (do_remove && !do_append) begin
			count_d = count_q - bfop_pkg::CNT_W'(1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bfop_pkg::LIMIT_RESET;
			mode_q  <= bfop_pkg::MODE_DROP_OLDEST;
		end else if (cfg_we) begin
			unique case (bfop_pkg::reg_idx_t'(cfg_idx))
				bfop_pkg::REG_QUEUE_LIMIT: begin
					limit_q <= cfg_wdata[bfop_pkg::LIMIT_W-1:0];
				end
				bfop_pkg::REG_OVERFLOW_MODE: begin
					mode_q <= bfop_pkg::mode_t'(cfg_wdata[bfop_pkg::MODE_W-1:0]);
				end
				default: ;
			endcase
		end
	end

	// pointers, count and closed flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
		end else if (accept) begin
			if (do_remove) begin
				head_q <= bfop_pkg::next_idx(head_q);
			end
			if (do_append) begin
				tail_q <= bfop_pkg::next_idx(tail_q);
			end
			if (do_close) begin
				closed_q <= 1'b1;
			end
			count_q <= count_d;
		end
	end

	// store write and registered head read; a word pushed by the previous item
	// is already in the array when the next item reads it
	always_ff @(posedge clk) begin
		if (accept && do_append) begin
			store_mem[tail_q] <= word;
		end
		if (accept) begin
			rdata_s1 <= store_mem[head_q];
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			popped_s1 <= (op == bfop_pkg::OP_POP) && do_remove;
			occ_s1    <= count_d;
			closed_s1 <= closed_q || do_close;
		end
	end

	assign m_tvalid = valid_s1;

	always_comb begin
		m_tdata = '0;
		m_tdata[bfop_pkg::STATUS_W-1:0] = status_s1;
		m_tdata[bfop_pkg::STATUS_W +: bfop_pkg::DATA_WIDTH] =
			popped_s1 ? rdata_s1 : '0;
		m_tdata[bfop_pkg::STATUS_W + bfop_pkg::DATA_WIDTH +: bfop_pkg::CNT_W] = occ_s1;
		m_tdata[bfop_pkg::OUT_BITS-1] = closed_s1;
	end

endmodule

`default_nettype wire

### test/bounded_fifo_overflow_policy_unit_tb.sv
// ----------------------------------------------------------------------------
// bounded_fifo_overflow_policy_unit_tb: self-checking bench for the FIFO unit
// Drives push / pop / close items with random gaps and back-pressure, tracks
// the queue contents in a scoreboard and checks every result field in order.
// ----------------------------------------------------------------------------
module bounded_fifo_overflow_policy_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 2000;   // cycles with no item moving on either side
	localparam int MAX_REPORTS = 10;
	localparam int MAX_GAP     = 18;
	localparam int PHASE_ITEMS = 62;
	localparam int AWAIT_DEPTH = 8;      // outcomes awaiting their result item

	// codes outside the defined sets, still reachable through the field widths
	localparam logic [bfop_pkg::OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [bfop_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	// one expected result item
	typedef struct {
		bfop_pkg::status_t               status;
		logic [bfop_pkg::DATA_WIDTH-1:0] pop_data;
		logic [bfop_pkg::CNT_W-1:0]      occupancy;
		logic                            closed;
	} outcome_t;

	// Tracks ring contents, count, closed flag and registers; holds the
	// outcome of every accepted item and checks results against it in order.
	class fifo_outcome_tracker;
		logic [bfop_pkg::DATA_WIDTH-1:0] words [bfop_pkg::DEPTH];
		int unsigned                     head;
		int unsigned                     tail;
		int unsigned                     count;
		bit                              closed;
		logic [bfop_pkg::LIMIT_W-1:0]    limit;
		logic [bfop_pkg::MODE_W-1:0]     mode;
		outcome_t                        awaited [AWAIT_DEPTH];
		int unsigned                     posted;    // outcomes noted so far
		int unsigned                     checked;   // outcomes matched so far
		int unsigned                     faults;

		function new();
			head    = 0;
			tail    = 0;
			count   = 0;
			closed  = 1'b0;
			limit   = bfop_pkg::LIMIT_RESET;
			mode    = bfop_pkg::MODE_DROP_OLDEST;
			posted  = 0;
			checked = 0;
			faults  = 0;
		endfunction

		function int unsigned outstanding();
			return posted - checked;
		endfunction

		function void set_register(input bfop_pkg::reg_idx_t idx,
		                           input logic [bfop_pkg::CFG_DATA_W-1:0] value);
			if (idx == bfop_pkg::REG_QUEUE_LIMIT) begin
				limit = value[bfop_pkg::LIMIT_W-1:0];
			end else begin
				mode = value[bfop_pkg::MODE_W-1:0];
			end
		endfunction

		// zero acts as one, anything above the ring size as the ring size
		function int unsigned capacity();
			int unsigned cap;
			cap = limit;
			if (cap < 1) begin
				cap = 1;
			end
			if (cap > bfop_pkg::DEPTH) begin
				cap = bfop_pkg::DEPTH;
			end
			return cap;
		endfunction

		function void note_fault(input string msg);
			faults++;
			if (faults <= MAX_REPORTS) begin
				$display("[%0t] mismatch: %s", $time, msg);
			end
		endfunction

		function void take_request(input logic [bfop_pkg::OP_W-1:0] op,
		                           input logic [bfop_pkg::DATA_WIDTH-1:0] word);
			outcome_t o;
			o.status   = bfop_pkg::ST_IGNORED;
			o.pop_data = '0;
			case (op)
				bfop_pkg::OP_PUSH: begin
					if (closed) begin
						o.status = bfop_pkg::ST_IGNORED;
					end else if (count >= capacity()) begin
						if (mode == bfop_pkg::MODE_DROP_OLDEST) begin
							// evict head, append at tail: count unchanged
							head        = (head + 1) % bfop_pkg::DEPTH;
							words[tail] = word;
							tail        = (tail + 1) % bfop_pkg::DEPTH;
							o.status    = bfop_pkg::ST_REPLACED;
						end else if (mode == bfop_pkg::MODE_DROP_NEWEST) begin
							o.status = bfop_pkg::ST_DROPPED;
						end else begin
							o.status = bfop_pkg::ST_REJECTED;
						end
					end else begin
						words[tail] = word;
						tail        = (tail + 1) % bfop_pkg::DEPTH;
						count++;
						o.status    = bfop_pkg::ST_APPENDED;
					end
				end
				bfop_pkg::OP_POP: begin
					if (count == 0) begin
						o.status = bfop_pkg::ST_EMPTY;
					end else begin
						o.pop_data = words[head];
						head       = (head + 1) % bfop_pkg::DEPTH;
						count--;
						o.status   = bfop_pkg::ST_POPPED;
					end
				end
				bfop_pkg::OP_CLOSE: begin
					closed = 1'b1;
				end
				default: begin
				end
			endcase
			o.occupancy = bfop_pkg::CNT_W'(count);
			o.closed    = closed;
			if (outstanding() >= AWAIT_DEPTH) begin
				note_fault("more items taken than results can be outstanding");
			end
			awaited[posted % AWAIT_DEPTH] = o;
			posted++;
		endfunction

		function void match_outcome(input logic [bfop_pkg::OUT_TDATA_W-1:0] beat);
			outcome_t                        want;
			logic [bfop_pkg::STATUS_W-1:0]   got_status;
			logic [bfop_pkg::DATA_WIDTH-1:0] got_data;
			logic [bfop_pkg::CNT_W-1:0]      got_occ;
			logic                            got_closed;
			got_status = beat[bfop_pkg::STATUS_W-1:0];
			got_data   = beat[bfop_pkg::STATUS_W +: bfop_pkg::DATA_WIDTH];
			got_occ    = beat[bfop_pkg::STATUS_W + bfop_pkg::DATA_WIDTH +: bfop_pkg::CNT_W];
			got_closed = beat[bfop_pkg::STATUS_W + bfop_pkg::DATA_WIDTH + bfop_pkg::CNT_W];
			if (outstanding() == 0) begin
				note_fault($sformatf("result with nothing awaited, tdata %h", beat));
				return;
			end
			want = awaited[checked % AWAIT_DEPTH];
			checked++;
			if (got_status !== want.status || got_data !== want.pop_data ||
			    got_occ !== want.occupancy || got_closed !== want.closed) begin
				note_fault($sformatf({"expected status %0d data %h occ %0d closed %0b, ",
					"got status %0d data %h occ %0d closed %0b"},
					want.status, want.pop_data, want.occupancy, want.closed,
					got_status, got_data, got_occ, got_closed));
			end
		endfunction
	endclass

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [bfop_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [bfop_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_we    = 1'b0;
	logic [bfop_pkg::CFG_IDX_W-1:0]   cfg_idx   = bfop_pkg::REG_QUEUE_LIMIT;
	logic [bfop_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	fifo_outcome_tracker tracker = new();

	bit          tx_steady = 1'b0;   // sender: no gaps this phase
	bit          rx_steady = 1'b0;   // receiver: no stalls this phase
	int unsigned quiet_cycles;

	always #5 clk = ~clk;

	bounded_fifo_overflow_policy_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	function automatic int draw_gap(input bit steady);
		if (steady) begin
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	// mostly random words, with the all-zero and all-one extremes now and then
	function automatic logic [bfop_pkg::DATA_WIDTH-1:0] random_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Offer one item after a random gap and hold it until taken. s_tvalid
	// stays high afterwards; the next call replaces the item or lowers it, and a
	// register write lowers it, in the same step, so no edge sees a stale item.
	task automatic send_request(input logic [bfop_pkg::OP_W-1:0] op,
	                            input logic [bfop_pkg::DATA_WIDTH-1:0] word);
		int gap;
		gap = draw_gap(tx_steady);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= bfop_pkg::IN_TDATA_W'({word, op});
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.take_request(op, word);
	endtask

	// Registers change only with the queue idle: all results back, plus the
	// result stage settled.
	task automatic write_register(input bfop_pkg::reg_idx_t idx,
	                              input logic [bfop_pkg::CFG_DATA_W-1:0] value);
		s_tvalid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_register(idx, value);
	endtask

	// Random mix: push_pct sets how hard the queue is driven towards full.
	// Close is only allowed in the last phase, as it cannot be undone.
	task automatic run_phase(input int items, input int push_pct, input bit allow_close);
		int roll;
		for (int i = 0; i < items; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct) begin
				send_request(bfop_pkg::OP_PUSH, random_word());
			end else if (roll < 96) begin
				send_request(bfop_pkg::OP_POP, random_word());
			end else if (roll < 98 || !allow_close) begin
				send_request(OP_UNUSED, random_word());
			end else begin
				send_request(bfop_pkg::OP_CLOSE, random_word());
			end
		end
	endtask

	// result side: random stalls per item, checks each accepted result
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(rx_steady);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			tracker.match_outcome(m_tdata);
		end
	end

	// watchdog: nothing accepted on either side for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("bounded_fifo_overflow_policy_unit_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int lim;
		int md;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset settings, limit 16, drop oldest ---
		send_request(bfop_pkg::OP_POP, '1);            // pop on empty queue
		send_request(bfop_pkg::OP_PUSH, '0);
		send_request(bfop_pkg::OP_PUSH, '1);
		send_request(bfop_pkg::OP_POP, '0);
		send_request(bfop_pkg::OP_POP, '0);
		send_request(bfop_pkg::OP_POP, '0);            // empty again
		send_request(OP_UNUSED, random_word());

		// limit zero acts as one; walk every overflow mode on a full queue
		write_register(bfop_pkg::REG_QUEUE_LIMIT, 5'd0);
		send_request(bfop_pkg::OP_PUSH, 32'h1234_5678);
		send_request(bfop_pkg::OP_PUSH, 32'h8765_4321); // replaces oldest
		write_register(bfop_pkg::REG_OVERFLOW_MODE,
			bfop_pkg::CFG_DATA_W'(bfop_pkg::MODE_DROP_NEWEST));
		send_request(bfop_pkg::OP_PUSH, random_word());
		write_register(bfop_pkg::REG_OVERFLOW_MODE,
			bfop_pkg::CFG_DATA_W'(bfop_pkg::MODE_REJECT));
		send_request(bfop_pkg::OP_PUSH, random_word());
		write_register(bfop_pkg::REG_OVERFLOW_MODE,
			bfop_pkg::CFG_DATA_W'(MODE_UNUSED));         // acts as reject
		send_request(bfop_pkg::OP_PUSH, random_word());
		send_request(bfop_pkg::OP_POP, '0);

		// limit dropped below occupancy: queue counts as full
		write_register(bfop_pkg::REG_QUEUE_LIMIT, 5'd16);
		write_register(bfop_pkg::REG_OVERFLOW_MODE,
			bfop_pkg::CFG_DATA_W'(bfop_pkg::MODE_DROP_OLDEST));
		repeat (5) send_request(bfop_pkg::OP_PUSH, random_word());
		write_register(bfop_pkg::REG_QUEUE_LIMIT, 5'd2);
		send_request(bfop_pkg::OP_PUSH, random_word());  // evict one, append one
		send_request(bfop_pkg::OP_POP, '0);

		// --- random phases over a range of settings, queue open ---
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: begin
					lim = 16;
					md  = bfop_pkg::MODE_DROP_OLDEST;
				end
				1: begin
					lim = 1;
					md  = bfop_pkg::MODE_DROP_NEWEST;
				end
				2: begin
					lim = 0;
					md  = bfop_pkg::MODE_REJECT;
				end
				3: begin
					lim = 31;                    // field maximum, clamps to ring size
					md  = MODE_UNUSED;
				end
				default: begin
					lim = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 31)
					                                  : $urandom_range(0, 16);
					md  = $urandom_range(0, 3);
				end
			endcase
			write_register(bfop_pkg::REG_QUEUE_LIMIT, bfop_pkg::CFG_DATA_W'(lim));
			write_register(bfop_pkg::REG_OVERFLOW_MODE, bfop_pkg::CFG_DATA_W'(md));
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			run_phase(PHASE_ITEMS, $urandom_range(35, 80), 1'b0);
		end

		// --- closing: fill a little, close, then drain past empty ---
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		send_request(bfop_pkg::OP_PUSH, random_word());
		send_request(bfop_pkg::OP_CLOSE, random_word());
		send_request(bfop_pkg::OP_PUSH, random_word());  // ignored once closed
		send_request(bfop_pkg::OP_CLOSE, random_word()); // closing twice is harmless
		run_phase(60, 25, 1'b1);

		s_tvalid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.faults == 0) begin
			$display("bounded_fifo_overflow_policy_unit_tb passed");
		end else begin
			$display("bounded_fifo_overflow_policy_unit_tb failed");
		end
		$finish;
	end

endmodule
